[rtl/lba_pkg.sv]
// Shared types and constants for the linked block allocator.
package lba_pkg;

  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;
  localparam int BLOCK_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int LINK_W   = 7;

  localparam logic [LINK_W-1:0] NULL_LINK = 7'd64;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                slot_step;
    logic                slot_take;
    logic                blk_step;
    logic                link_end;
    logic                walk_rd;
    logic                emit_ok;
    logic                emit_err;
    logic [STATUS_W-1:0] err_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero;
    logic too_big;
    logic slot_free;
    logic slot_end;
    logic blk_done;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/lba_ctrl.sv]
// Request sequencer for the linked block allocator.
module lba_ctrl import lba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SLOT  = 3'd2;
  localparam logic [2:0] S_BLK   = 3'd3;
  localparam logic [2:0] S_LEND  = 3'd4;
  localparam logic [2:0] S_WRD   = 3'd5;
  localparam logic [2:0] S_WEM   = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [STATUS_W-1:0] err_q, err_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.err_code = err_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.zero) begin
          err_d   = ST_ZERO;
          state_d = S_ERR;
        end else if (sts_i.too_big) begin
          err_d   = ST_NOSPACE;
          state_d = S_ERR;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        if (sts_i.slot_free) begin
          cmd_o.slot_take = 1'b1;
          state_d         = S_BLK;
        end else if (sts_i.slot_end) begin
          err_d   = ST_FULL;
          state_d = S_ERR;
        end else begin
          cmd_o.slot_step = 1'b1;
        end
      end
      S_BLK: begin
        cmd_o.blk_step = 1'b1;
        if (sts_i.blk_done) state_d = S_LEND;
      end
      S_LEND: begin
        cmd_o.link_end = 1'b1;
        state_d        = S_WRD;
      end
      S_WRD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WEM;
      end
      S_WEM: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ok = 1'b1;
          state_d       = sts_i.walk_last ? S_IDLE : S_WRD;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

[rtl/lba_datapath.sv]
// Used-block boundary, file table, link memory and result register.
module lba_datapath import lba_pkg::*; #(
  parameter int DISK_BLOCKS = 64,
  parameter int FILE_SLOTS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [COUNT_W-1:0]  block_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   file_slot_o,
  output logic [BLOCK_W-1:0]  start_block_o,
  output logic [BLOCK_W-1:0]  block_index_o,
  output logic [COUNT_W-1:0]  free_blocks_o,
  output logic                last_o
);

  localparam int MaxN = (DISK_BLOCKS > FILE_SLOTS) ? DISK_BLOCKS : FILE_SLOTS;
  localparam int IW   = $clog2(MaxN);
  localparam int AW   = $clog2(DISK_BLOCKS);
  localparam int SW   = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;

  logic [FILE_SLOTS-1:0]  slot_valid_q;
  logic [COUNT_W-1:0]     free_q;
  logic [COUNT_W-1:0]     want_q;
  logic [COUNT_W-1:0]     cnt_q;
  logic [IW-1:0]          idx_q;
  logic [SW-1:0]          slot_q;
  logic [AW-1:0]          start_q;
  logic [AW-1:0]          prev_q;
  logic [LINK_W-1:0]      cur_q;
  logic [LINK_W-1:0]      rd_q;

  logic [LINK_W-1:0]      link_mem [DISK_BLOCKS];

  logic [COUNT_W-1:0]     used_cnt;
  logic                   take;
  logic                   mem_we;
  logic [LINK_W-1:0]      mem_wdata;

  // blocks are taken lowest first and never released, so the used ones
  // always run from block 0 up to used_cnt - 1
  assign used_cnt = COUNT_W'(DISK_BLOCKS) - free_q;
  assign take     = (COUNT_W'(idx_q[AW-1:0]) >= used_cnt);

  assign sts_o.zero      = (want_q == '0);
  assign sts_o.too_big   = (want_q > free_q);
  assign sts_o.slot_free = !slot_valid_q[idx_q[SW-1:0]];
  assign sts_o.slot_end  = (idx_q == IW'(FILE_SLOTS - 1));
  assign sts_o.blk_done  = take && ((cnt_q + 7'd1) == want_q);
  assign sts_o.walk_last = (cnt_q == 7'd1);
  assign sts_o.out_free  = !out_valid_o || !out_stall_i;

  // link writes always go to the previous block of the chain
  assign mem_we    = (cmd_i.blk_step && take && (cnt_q != '0)) || cmd_i.link_end;
  assign mem_wdata = cmd_i.link_end ? NULL_LINK : LINK_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[prev_q] <= mem_wdata;
    if (cmd_i.walk_rd) rd_q <= link_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      free_q       <= COUNT_W'(DISK_BLOCKS);
    end else begin
      if (cmd_i.slot_take) slot_valid_q[idx_q[SW-1:0]] <= 1'b1;
      if (cmd_i.link_end) free_q <= free_q - want_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      want_q <= block_count_i;
      idx_q  <= '0;
    end
    if (cmd_i.slot_step) idx_q <= idx_q + 1'b1;
    if (cmd_i.slot_take) begin
      slot_q <= idx_q[SW-1:0];
      idx_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.blk_step) begin
      idx_q <= idx_q + 1'b1;
      if (take) begin
        if (cnt_q == '0) start_q <= idx_q[AW-1:0];
        prev_q <= idx_q[AW-1:0];
        cnt_q  <= cnt_q + 7'd1;
      end
    end
    if (cmd_i.link_end) cur_q <= LINK_W'(start_q);
    if (cmd_i.emit_ok) begin
      cur_q <= rd_q;
      cnt_q <= cnt_q - 7'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_ok || cmd_i.emit_err) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ok) begin
      status_o      <= ST_OK;
      file_slot_o   <= SLOT_W'(slot_q);
      start_block_o <= BLOCK_W'(start_q);
      block_index_o <= BLOCK_W'(cur_q);
      free_blocks_o <= free_q;
      last_o        <= (cnt_q == 7'd1);
    end else if (cmd_i.emit_err) begin
      status_o      <= cmd_i.err_code;
      file_slot_o   <= '0;
      start_block_o <= '0;
      block_index_o <= '0;
      free_blocks_o <= free_q;
      last_o        <= 1'b1;
    end
  end

endmodule

[rtl/linked_block_allocator_core.sv]
// Top level of the linked block allocator: sequencer plus datapath.
//
//  Channel  Direction  Handshake               Payload
//  request  in         in_valid_i / in_stall_o block_count_i
//  result   out        out_valid_o/ out_stall_i status, file_slot, start_block,
//                                              block_index, free_blocks, last
//
// One request at a time. A zero-length or oversized request gives its single
// transaction; a full table gives it after the slot search. A granted one
// checks the slots in turn, scans block positions one a cycle up to the last
// block taken, and does a registered link memory read per chained block in
// the walk. Result stalls hold the sequencer; the result register frees the
// request side as soon as the last transaction is loaded.
// Reset (asynchronous, active low) frees all blocks and slots at once; the link
// memory needs no clearing pass, since only links written by the current
// request are read back.
module linked_block_allocator_core import lba_pkg::*; #(
  parameter int DISK_BLOCKS = 64,
  parameter int FILE_SLOTS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [COUNT_W-1:0]  block_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   file_slot_o,
  output logic [BLOCK_W-1:0]  start_block_o,
  output logic [BLOCK_W-1:0]  block_index_o,
  output logic [COUNT_W-1:0]  free_blocks_o,
  output logic                last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: check, slot search, block scan, link close, chain walk, error result
  lba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // state, link memory and the result register
  lba_datapath #(
    .DISK_BLOCKS (DISK_BLOCKS),
    .FILE_SLOTS  (FILE_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .block_count_i (block_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .file_slot_o   (file_slot_o),
    .start_block_o (start_block_o),
    .block_index_o (block_index_o),
    .free_blocks_o (free_blocks_o),
    .last_o        (last_o)
  );

endmodule

[rtl/lba_checker.sv]
// Port-level checks for the linked block allocator, bound to the top level.
module lba_checker import lba_pkg::*; #(
  parameter int DISK_BLOCKS = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [COUNT_W-1:0]  block_count_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [SLOT_W-1:0]   file_slot_o,
  input logic [BLOCK_W-1:0]  start_block_o,
  input logic [BLOCK_W-1:0]  block_index_o,
  input logic [COUNT_W-1:0]  free_blocks_o,
  input logic                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_index_o) &&
    $stable(status_o) && $stable(last_o))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (file_slot_o == '0) &&
    (start_block_o == '0) && (block_index_o == '0))
    else $error("error transaction with non-zero fields or not last");

  a_chain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> block_index_o >= start_block_o)
    else $error("chain block below its start block");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_blocks_o <= COUNT_W'(DISK_BLOCKS))
    else $error("free block count above disk size");

endmodule

bind linked_block_allocator_core lba_checker #(.DISK_BLOCKS(DISK_BLOCKS)) u_lba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .block_count_i (block_count_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .file_slot_o   (file_slot_o),
  .start_block_o (start_block_o),
  .block_index_o (block_index_o),
  .free_blocks_o (free_blocks_o),
  .last_o        (last_o)
);
